[design/ptc_pkg.sv]
`default_nettype none
package ptc_pkg;

	// pipeline depth, input register through output register
	localparam int unsigned NUM_STAGES = 10;

	// config address width: six 32-bit registers at 4*i
	localparam int unsigned CFG_AW = 5;

	// datapath widths
	localparam int unsigned TW  = 20;	// temperature and its corrections
	localparam int unsigned WW  = 40;	// OFF and SENS terms
	localparam int unsigned TIW = 18;	// second-order temperature term Ti

	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
	} cal_t;

	// first-order terms, stage 3 -> stage 4
	typedef struct packed {
		logic signed [TW-1:0] temp;
		logic signed [WW-1:0] off;
		logic signed [WW-1:0] sens;
		logic [TIW-1:0]       ti_lo;
		logic [TIW-1:0]       ti_hi;
		logic [23:0]          d1;
	} first_t;

	// corrected terms, stage 6 -> stage 7
	typedef struct packed {
		logic signed [TW-1:0] temp;
		logic signed [WW-1:0] off;
		logic signed [WW-1:0] sens;
		logic [23:0]          d1;
	} second_t;

	localparam logic signed [TW-1:0] TEMP_REF  = TW'(2000);
	localparam logic signed [TW-1:0] B_OFS     = TW'(1500);
	// TEMP/100 < -15 (toward zero) is TEMP <= -1600
	localparam logic signed [TW-1:0] TEMP_VLOW = TW'(-1599);

	// signed divide by 2^sh, rounding toward zero
	function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] x,
		input int unsigned sh);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage
`default_nettype wire

[design/ptc_cfg_regs.sv]
`default_nettype none
module ptc_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ptc_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output ptc_pkg::cal_t                    cal
);
	import ptc_pkg::*;

	cal_t     cal_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_C1: cal_q.c1 <= pwdata[15:0];
				REG_C2: cal_q.c2 <= pwdata[15:0];
				REG_C3: cal_q.c3 <= pwdata[15:0];
				REG_C4: cal_q.c4 <= pwdata[15:0];
				REG_C5: cal_q.c5 <= pwdata[15:0];
				REG_C6: cal_q.c6 <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_C1: prdata = {16'h0000, cal_q.c1};
			REG_C2: prdata = {16'h0000, cal_q.c2};
			REG_C3: prdata = {16'h0000, cal_q.c3};
			REG_C4: prdata = {16'h0000, cal_q.c4};
			REG_C5: prdata = {16'h0000, cal_q.c5};
			REG_C6: prdata = {16'h0000, cal_q.c6};
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[design/ptc_pipe_ctrl.sv]
`default_nettype none
module ptc_pipe_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             m_tready,
	output logic                                  s_tready,
	output logic                                  m_tvalid,
	output logic [ptc_pkg::NUM_STAGES-1:0]        en
);
	import ptc_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] vld_nxt;
	logic [NUM_STAGES-1:0] shifted;
	logic [NUM_STAGES-1:0] lowfill;

	// stage k may load when any stage from k to the end is empty,
	// or the output beat is being taken
	always_comb begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			lowfill = (NUM_STAGES'(1) << k) - NUM_STAGES'(1);
			en[k]   = m_tready || !(&(vld_q | lowfill));
		end
	end

	assign shifted = {vld_q[NUM_STAGES-2:0], s_tvalid};

	always_comb begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			vld_nxt[k] = en[k] ? shifted[k] : vld_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_nxt;
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];

`ifndef SYNTHESIS
	logic in_fire, out_fire;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	a_occ_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !out_fire) |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
		else $error("occupancy did not grow on input-only beat");

	a_occ_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_fire && out_fire) |=> $countones(vld_q) == $past($countones(vld_q)) - 1)
		else $error("occupancy did not shrink on output-only beat");

	a_occ_same: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire == out_fire) |=> $countones(vld_q) == $past($countones(vld_q)))
		else $error("occupancy changed without a matching beat");

	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tready && (&vld_q)) |-> !s_tready)
		else $error("input taken while every stage is full and stalled");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> vld_q[0])
		else $error("accepted beat missing from first stage");
`endif

endmodule
`default_nettype wire

[design/ptc_first_order.sv]
`default_nettype none
module ptc_first_order (
	input  wire logic           clk,
	input  wire logic [2:0]     en,
	input  wire ptc_pkg::cal_t  cal,
	input  wire logic [23:0]    raw_pressure,
	input  wire logic [23:0]    raw_temp,
	output ptc_pkg::first_t     res
);
	import ptc_pkg::*;

	// stage 1: dT
	logic signed [24:0] dt_c;
	logic signed [24:0] dt_s1;
	logic [23:0]        d1_s1;

	assign dt_c = signed'({1'b0, raw_temp}) - signed'({1'b0, cal.c5, 8'h00});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= dt_c;
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: coefficient products and dT^2
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	logic signed [49:0] dtsq_c;
	logic [48:0]        dtsq_s2;
	logic [23:0]        d1_s2;

	assign dtsq_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p6_s2   <= dt_s1 * signed'({1'b0, cal.c6});
			p4_s2   <= dt_s1 * signed'({1'b0, cal.c4});
			p3_s2   <= dt_s1 * signed'({1'b0, cal.c3});
			dtsq_s2 <= dtsq_c[48:0];
			d1_s2   <= d1_s1;
		end
	end

	// stage 3: TEMP, OFF, SENS and both candidate Ti terms
	logic signed [63:0]   t6, t4, t3;
	logic [50:0]          dtsq3;
	logic signed [TW-1:0] temp_s3;
	logic signed [WW-1:0] off_s3, sens_s3;
	logic [TIW-1:0]       ti_lo_s3, ti_hi_s3;
	logic [23:0]          d1_s3;

	assign t6    = trunc_shift(64'(p6_s2), 23);
	assign t4    = trunc_shift(64'(p4_s2), 7);
	assign t3    = trunc_shift(64'(p3_s2), 8);
	assign dtsq3 = {2'b00, dtsq_s2} + {1'b0, dtsq_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			temp_s3  <= TEMP_REF + t6[TW-1:0];
			off_s3   <= WW'({cal.c2, 16'h0000}) + t4[WW-1:0];
			sens_s3  <= WW'({cal.c1, 15'h0000}) + t3[WW-1:0];
			ti_lo_s3 <= dtsq3[50:33];
			ti_hi_s3 <= TIW'(dtsq_s2[48:36]);
			d1_s3    <= d1_s2;
		end
	end

	always_comb begin
		res.temp  = temp_s3;
		res.off   = off_s3;
		res.sens  = sens_s3;
		res.ti_lo = ti_lo_s3;
		res.ti_hi = ti_hi_s3;
		res.d1    = d1_s3;
	end

endmodule
`default_nettype wire

[design/ptc_second_order.sv]
`default_nettype none
module ptc_second_order (
	input  wire logic             clk,
	input  wire logic [2:0]       en,
	input  wire ptc_pkg::first_t  fo,
	output ptc_pkg::second_t      so
);
	import ptc_pkg::*;

	// stage 4: branch select and squares of (TEMP-2000), (TEMP+1500)
	logic signed [TW-1:0]   a_c, b_c;
	logic signed [2*TW-1:0] asq_c, bsq_c;
	logic [35:0]            asq_s4, bsq_s4;
	logic                   low_s4, vlow_s4;
	logic [TIW-1:0]         ti_s4;
	logic signed [TW-1:0]   temp_s4;
	logic signed [WW-1:0]   off_s4, sens_s4;
	logic [23:0]            d1_s4;

	assign a_c   = fo.temp - TEMP_REF;
	assign b_c   = fo.temp + B_OFS;
	assign asq_c = a_c * a_c;
	assign bsq_c = b_c * b_c;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			asq_s4  <= asq_c[35:0];
			bsq_s4  <= bsq_c[35:0];
			low_s4  <= fo.temp < TEMP_REF;
			vlow_s4 <= fo.temp < TEMP_VLOW;
			ti_s4   <= (fo.temp < TEMP_REF) ? fo.ti_lo : fo.ti_hi;
			temp_s4 <= fo.temp;
			off_s4  <= fo.off;
			sens_s4 <= fo.sens;
			d1_s4   <= fo.d1;
		end
	end

	// stage 5: OFFi, SENSi, corrected TEMP
	logic [WW-1:0]        a3, a5, b7, b4;
	logic [WW-1:0]        offi_c, sensi_c;
	logic [WW-1:0]        offi_s5, sensi_s5;
	logic signed [TW-1:0] temp_s5;
	logic signed [WW-1:0] off_s5, sens_s5;
	logic [23:0]          d1_s5;

	always_comb begin
		a3 = WW'({asq_s4, 1'b0}) + WW'(asq_s4);
		a5 = WW'({asq_s4, 2'b00}) + WW'(asq_s4);
		b7 = WW'({bsq_s4, 3'b000}) - WW'(bsq_s4);
		b4 = WW'({bsq_s4, 2'b00});
		if (low_s4) begin
			offi_c  = (a3 >> 1) + (vlow_s4 ? b7 : '0);
			sensi_c = (a5 >> 3) + (vlow_s4 ? b4 : '0);
		end else begin
			offi_c  = WW'(asq_s4 >> 4);
			sensi_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			offi_s5  <= offi_c;
			sensi_s5 <= sensi_c;
			temp_s5  <= temp_s4 - signed'(TW'(ti_s4));
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			d1_s5    <= d1_s4;
		end
	end

	// stage 6: OFF2, SENS2
	logic signed [WW-1:0] off_s6, sens_s6;
	logic signed [TW-1:0] temp_s6;
	logic [23:0]          d1_s6;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			off_s6  <= off_s5 - signed'(offi_s5);
			sens_s6 <= sens_s5 - signed'(sensi_s5);
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
		end
	end

	always_comb begin
		so.temp = temp_s6;
		so.off  = off_s6;
		so.sens = sens_s6;
		so.d1   = d1_s6;
	end

endmodule
`default_nettype wire

[design/ptc_pressure.sv]
`default_nettype none
module ptc_pressure (
	input  wire logic              clk,
	input  wire logic [3:0]        en,
	input  wire ptc_pkg::second_t  so,
	output logic signed [31:0]     pressure_out,
	output logic signed [18:0]     temperature_out
);
	import ptc_pkg::*;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	// stage 7: D1*SENS2 split at bit 20 of SENS2
	logic [43:0]          pplo_s7;
	logic signed [44:0]   pphi_s7;
	logic signed [WW-1:0] off_s7;
	logic signed [TW-1:0] temp_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pplo_s7 <= so.d1 * so.sens[19:0];
			pphi_s7 <= signed'({1'b0, so.d1}) * signed'(so.sens[WW-1:20]);
			off_s7  <= so.off;
			temp_s7 <= so.temp;
		end
	end

	// stage 8: recombine partial products
	logic signed [63:0]   prod_s8;
	logic signed [WW-1:0] off_s8;
	logic signed [TW-1:0] temp_s8;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s8 <= (64'(pphi_s7) <<< 20) + {20'h00000, pplo_s7};
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: /2^21 toward zero, minus OFF2
	logic signed [63:0]   q_c;
	logic signed [47:0]   diff_s9;
	logic signed [TW-1:0] temp_s9;

	assign q_c = trunc_shift(prod_s8, 21);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			diff_s9 <= q_c[47:0] - 48'(off_s8);
			temp_s9 <= temp_s8;
		end
	end

	// stage 10: /2^13 toward zero, saturate; output register
	logic signed [63:0] p_c;
	logic signed [63:0] psat_c;
	logic signed [31:0] press_s10;
	logic signed [18:0] temp_s10;

	assign p_c = trunc_shift(64'(diff_s9), 13);

	always_comb begin
		if (p_c > SAT_HI) begin
			psat_c = SAT_HI;
		end else if (p_c < SAT_LO) begin
			psat_c = SAT_LO;
		end else begin
			psat_c = p_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			press_s10 <= psat_c[31:0];
			temp_s10  <= temp_s9[18:0];
		end
	end

	assign pressure_out    = press_s10;
	assign temperature_out = temp_s10;

endmodule
`default_nettype wire

[design/pressure_temp_compensation_core.sv]
`default_nettype none
// Second-order temperature-compensated pressure and temperature from one raw
// 24-bit pressure conversion (D1) and one raw 24-bit temperature conversion
// (D2), using the six 16-bit factory calibration words C1..C6. Load C1..C6
// over the APB port (byte address 4*i, C1 at 0) while no beat is in flight;
// all six reset to zero. Input beats carry {D2, D1}; output beats carry
// {temperature in 0.01 degC (19-bit signed), pressure in 0.1 mbar (32-bit
// signed, saturated)}. The datapath is a ten-stage pipeline: it takes and gives one beat
// per clock while the output side is ready. Each stage holds its own multiplies or
// wide adds, among them the D1*SENS2 partial products and the final
// divide-and-saturate. Every stage has its own valid bit and loads whenever
// some stage at or after it is empty or the output side is ready, so bubbles are
// squeezed out under back-pressure and the input keeps taking beats while a result
// waits. All power-of-two divides round toward zero.
module pressure_temp_compensation_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ptc_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [47:0]                 s_tdata,	// [23:0] raw_pressure, [47:24] raw_temp
	// output stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [55:0]                      m_tdata	// [31:0] pressure_out, [50:32] temperature_out, [55:51] zero
);
	import ptc_pkg::*;

	cal_t                  cal;
	logic [NUM_STAGES-1:0] en;
	first_t                fo;
	second_t               so;
	logic signed [31:0]    pressure_out;
	logic signed [18:0]    temperature_out;

	ptc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	// valid bits and per-stage load enables
	ptc_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.en       (en)
	);

	// stages 1-3: dT, TEMP, OFF, SENS
	ptc_first_order u_first (
		.clk          (clk),
		.en           (en[2:0]),
		.cal          (cal),
		.raw_pressure (s_tdata[23:0]),
		.raw_temp     (s_tdata[47:24]),
		.res          (fo)
	);

	// stages 4-6: low / very-low / high temperature correction
	ptc_second_order u_second (
		.clk (clk),
		.en  (en[5:3]),
		.fo  (fo),
		.so  (so)
	);

	// stages 7-10: pressure equation and output register
	ptc_pressure u_press (
		.clk             (clk),
		.en              (en[9:6]),
		.so              (so),
		.pressure_out    (pressure_out),
		.temperature_out (temperature_out)
	);

	assign m_tdata = {5'b00000, temperature_out, pressure_out};

endmodule
`default_nettype wire
